FILE: design/ascii_to_unsigned_parser_macros.svh
// ============================================================================
// ascii_to_unsigned_parser_macros.svh
// Assertion macros for the ASCII-to-unsigned parser. They compile to nothing
// when SYNTH is defined.
// ============================================================================
`ifndef ASCII_TO_UNSIGNED_PARSER_MACROS_SVH
`define ASCII_TO_UNSIGNED_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define A2U_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a2u assertion failed");
// next-cycle implication
`define A2U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a2u assertion failed");
`else
`define A2U_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define A2U_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/a2u_pkg.sv
// ============================================================================
// a2u_pkg
// Shared types and constants of the ASCII-to-unsigned parser.
// ============================================================================
package a2u_pkg;

    // classified character, front to back
    typedef struct packed {
        logic       is_end;    // zero byte
        logic       is_zero;   // '0'
        logic       is_x;      // lowercase x
        logic       is_o;      // lowercase o
        logic       is_alnum;  // 0-9, a-z, A-Z
        logic [5:0] digit;     // digit value 0..35
    } t_class_item;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_X  = 8'h78;
    localparam logic [7:0] CHAR_LC_O  = 8'h6F;

    // offsets to digit values
    localparam logic [7:0] OFS_LC     = 8'd87;  // 'a' - 10
    localparam logic [7:0] OFS_UC     = 8'd55;  // 'A' - 10

    localparam logic [1:0] RADIX_DEC  = 2'd0;
    localparam logic [1:0] RADIX_HEX  = 2'd1;
    localparam logic [1:0] RADIX_OCT  = 2'd2;

    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] BASE_OCT   = 6'd8;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_DIGIT = 2'd1;
    localparam logic [1:0] STATUS_TOO_BIG   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

FILE: design/a2u_front.sv
// ============================================================================
// a2u_front
// Accepts characters and classifies them into a registered item.
// ============================================================================
module a2u_front
    import a2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_character,
    output logic        o_stall,
    output logic        o_valid,
    output t_class_item o_item,
    input  logic        i_stall
);

    logic        r_valid;
    t_class_item r_item;
    t_class_item n_item;
    logic        take;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;

    always_comb begin
        n_item          = '0;
        n_item.is_end   = (i_character == CHAR_NUL);
        n_item.is_zero  = (i_character == CHAR_ZERO);
        n_item.is_x     = (i_character == CHAR_LC_X);
        n_item.is_o     = (i_character == CHAR_LC_O);
        if (i_character >= CHAR_ZERO && i_character <= CHAR_NINE) begin
            n_item.is_alnum = 1'b1;
            n_item.digit    = 6'(i_character - CHAR_ZERO);
        end else if (i_character >= CHAR_LC_A && i_character <= CHAR_LC_Z) begin
            n_item.is_alnum = 1'b1;
            n_item.digit    = 6'(i_character - OFS_LC);
        end else if (i_character >= CHAR_UC_A && i_character <= CHAR_UC_Z) begin
            n_item.is_alnum = 1'b1;
            n_item.digit    = 6'(i_character - OFS_UC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: design/a2u_queue.sv
// ============================================================================
// a2u_queue
// Short FIFO of classified items between front and back.
// ============================================================================
module a2u_queue
    import a2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_class_item i_item,
    output logic        o_stall,
    output logic        o_valid,
    output t_class_item o_item,
    input  logic        i_stall
);

    t_class_item           r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  push;
    logic                  pop;

    assign o_stall = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: design/a2u_back.sv
// ============================================================================
// a2u_back
// Parser state, digit accumulation and the registered result.
// ============================================================================
module a2u_back
    import a2u_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_class_item            i_item,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [1:0]             o_status,
    input  logic                   i_stall
);

    logic [VALUE_WIDTH-1:0] r_acc,   n_acc;
    logic [1:0]             r_radix, n_radix;
    logic [1:0]             r_pos,   n_pos;
    logic                   r_saw,   n_saw;
    logic [1:0]             r_err,   n_err;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [1:0]             r_status;

    logic                   pop;
    logic [5:0]             base;
    logic [1:0]             pos_inc;
    logic [VALUE_WIDTH-1:0] scaled;

    // a terminator needs the result register free
    assign o_stall = i_item.is_end && r_out_valid && i_stall;
    assign pop     = i_valid && !o_stall;
    assign pos_inc = (r_pos == 2'd2) ? r_pos : r_pos + 2'd1;

    always_comb begin
        case (r_radix)
            RADIX_HEX: base = BASE_HEX;
            RADIX_OCT: base = BASE_OCT;
            default:   base = BASE_DEC;
        endcase
        case (r_radix)
            RADIX_HEX: scaled = r_acc << 4;
            RADIX_OCT: scaled = r_acc << 3;
            default:   scaled = (r_acc << 3) + (r_acc << 1);
        endcase
    end

    always_comb begin
        n_acc   = r_acc;
        n_radix = r_radix;
        n_pos   = r_pos;
        n_saw   = r_saw;
        n_err   = r_err;
        if (pop) begin
            if (i_item.is_end) begin
                n_acc   = '0;
                n_radix = RADIX_DEC;
                n_pos   = 2'd0;
                n_saw   = 1'b0;
                n_err   = STATUS_OK;
            end else if (r_err != STATUS_OK) begin
                n_err = r_err;
            end else if (r_pos == 2'd0 && i_item.is_zero) begin
                n_saw = 1'b1;
                n_pos = pos_inc;
            end else if (r_saw && r_pos == 2'd1 && (i_item.is_x || i_item.is_o)) begin
                n_radix = i_item.is_x ? RADIX_HEX : RADIX_OCT;
                n_pos   = pos_inc;
            end else if (!i_item.is_alnum) begin
                n_err = STATUS_NOT_DIGIT;
            end else if (i_item.digit >= base) begin
                n_err = STATUS_TOO_BIG;
            end else begin
                n_acc = scaled + VALUE_WIDTH'(i_item.digit);
                n_pos = pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_radix     <= RADIX_DEC;
            r_pos       <= 2'd0;
            r_saw       <= 1'b0;
            r_err       <= STATUS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_radix <= n_radix;
            r_pos   <= n_pos;
            r_saw   <= n_saw;
            r_err   <= n_err;
            if (pop && i_item.is_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (pop && i_item.is_end) begin
            r_value  <= (r_err != STATUS_OK) ? '0 : r_acc;
            r_status <= r_err;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

FILE: design/ascii_to_unsigned_parser.sv
// ============================================================================
// ascii_to_unsigned_parser
// Parses a zero-terminated ASCII string into an unsigned number with an
// optional 0x / 0o radix prefix.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall / i_character): one character per beat.
//   A zero byte ends the string; only that beat yields a result.
//   Output channel (o_valid / i_stall / o_value, o_status): one beat per
//   string, value 0 with a nonzero status on error (1 = not a digit or letter,
//   2 = digit not below the base).
//   The result of a terminator passes the classify register, a queue entry
//   and the result register, in that order, before it is on the output.
//   Throughput: one character per cycle while nothing downstream stalls;
//   the accumulate step is a shift-and-add (x8, x10, x16) in the back end.
//   A four-entry queue separates classification from accumulation, so the
//   input keeps flowing while a finished result waits on the output.
//   When the receiver stalls, the result holds; further characters are still
//   taken until a second terminator reaches the back end and the queue fills.
//   Reset (synchronous, active low) empties the pipeline and returns the
//   parser to decimal with a zero accumulator and no error.
// ============================================================================
`include "ascii_to_unsigned_parser_macros.svh"

module ascii_to_unsigned_parser
    import a2u_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_character,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [1:0]             o_status,
    input  logic                   i_stall
);

    // front -> queue
    logic        front_valid;
    t_class_item front_item;
    logic        queue_full;
    // queue -> back
    logic        queue_valid;
    t_class_item queue_item;
    logic        back_stall;

    // classify each character into digit value and prefix flags
    a2u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_character (i_character),
        .o_stall     (o_stall),
        .o_valid     (front_valid),
        .o_item      (front_item),
        .i_stall     (queue_full)
    );

    a2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_stall (queue_full),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_stall (back_stall)
    );

    // sticky error, radix prefix and accumulator live here
    a2u_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_item   (queue_item),
        .o_stall  (back_stall),
        .o_valid  (o_valid),
        .o_value  (o_value),
        .o_status (o_status),
        .i_stall  (i_stall)
    );

    // an errored result always carries a zero value
    `A2U_ASSERT_NOW(a_err_value_zero, i_clk, i_rst_n, o_valid && (o_status != STATUS_OK), o_value == '0)
    // status is one of the defined codes
    `A2U_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_valid, (o_status == STATUS_OK) || (o_status == STATUS_NOT_DIGIT) || (o_status == STATUS_TOO_BIG))
    // an item held at a full queue is not dropped by the front register
    `A2U_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, front_valid && queue_full, front_valid)
    // the back end only blocks on a terminator while the result is stalled
    `A2U_ASSERT_NOW(a_back_stall_cause, i_clk, i_rst_n, back_stall, queue_item.is_end && o_valid && i_stall)

endmodule

FILE: test/a2u_result_checker.sv
// ----------------------------------------------------------------------------
// a2u_result_checker
// Watches both channels of the ASCII-to-unsigned parser, keeps its own
// parse state to predict the result of every terminated string, and
// compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module a2u_result_checker
    import a2u_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [7:0]             i_in_char,
    input  logic                   i_in_stall,
    input  logic                   i_out_valid,
    input  logic [VALUE_WIDTH-1:0] i_out_value,
    input  logic [1:0]             i_out_status,
    input  logic                   i_out_stall,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [1:0]             status;
    } parse_result_t;

    parse_result_t          expected_results[$];
    int                     error_total = 0;

    // predicted parse state
    logic [VALUE_WIDTH-1:0] acc;
    logic [1:0]             radix;
    logic [1:0]             pos;
    logic                   lead_zero;
    logic [1:0]             err;

    task automatic clear_parse();
        acc       = '0;
        radix     = RADIX_DEC;
        pos       = 2'd0;
        lead_zero = 1'b0;
        err       = STATUS_OK;
    endtask

    task automatic flag_error(input string msg);
        if (error_total < 10) begin
            $display("%0t ns: %s", $realtime, msg);
        end
        error_total++;
    endtask

    task automatic take_char(input logic [7:0] c);
        logic [5:0]    digit;
        logic          alnum;
        logic [5:0]    base;
        parse_result_t res;
        alnum = 1'b1;
        digit = '0;
        base  = (radix == RADIX_HEX) ? BASE_HEX : (radix == RADIX_OCT) ? BASE_OCT : BASE_DEC;
        if (c == CHAR_NUL) begin
            res.value  = (err == STATUS_OK) ? acc : '0;
            res.status = err;
            expected_results.push_back(res);
            clear_parse();
        end else if (err != STATUS_OK) begin
            // sticky error: skip up to the terminator
        end else if (pos == 2'd0 && c == CHAR_ZERO) begin
            lead_zero = 1'b1;
            pos       = 2'd1;
        end else if (lead_zero && pos == 2'd1 && (c == CHAR_LC_X || c == CHAR_LC_O)) begin
            radix = (c == CHAR_LC_X) ? RADIX_HEX : RADIX_OCT;
            pos   = 2'd2;
        end else begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                digit = 6'(c - CHAR_ZERO);
            end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
                digit = 6'(c - CHAR_LC_A + 8'd10);
            end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
                digit = 6'(c - CHAR_UC_A + 8'd10);
            end else begin
                alnum = 1'b0;
            end
            if (!alnum) begin
                err = STATUS_NOT_DIGIT;
            end else if (digit >= base) begin
                err = STATUS_TOO_BIG;
            end else begin
                acc = acc * VALUE_WIDTH'(base) + VALUE_WIDTH'(digit);
                if (pos != 2'd2) begin
                    pos = pos + 2'd1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        parse_result_t want;
        if (!i_rst_n) begin
            clear_parse();
            expected_results.delete();
        end else begin
            // compare first: a beat taken at this edge cannot be the result shown now
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("unexpected result value %h status %0d",
                                         i_out_value, i_out_status));
                end else begin
                    want = expected_results.pop_front();
                    if (want.value !== i_out_value || want.status !== i_out_status) begin
                        flag_error($sformatf("result mismatch: value exp %h got %h, status exp %0d got %0d",
                                             want.value, i_out_value, want.status, i_out_status));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_char(i_in_char);
            end
        end
        o_fail_count <= error_total;
        o_pending    <= expected_results.size();
    end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives strings into the ASCII-to-unsigned parser: a directed set of
// prefix and error corner cases, then random strings under three idle
// mixes, with a long output hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import a2u_pkg::*;

    localparam int VALUE_WIDTH     = 32;
    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int BEATS_PER_PHASE = 250;   // three phases, ~750 characters
    localparam int HOLD_CYCLES     = 300;   // long output hold-off
    localparam int DRAIN_CYCLES    = 20;    // extra margin after the drain

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic [7:0]             i_character;
    logic                   i_stall;
    logic                   o_stall;
    logic                   o_valid;
    logic [VALUE_WIDTH-1:0] o_value;
    logic [1:0]             o_status;

    int fail_count;
    int pending;

    // idle rates in percent, changed per phase by the stimulus process
    int tx_idle_pct = 31;
    int rx_idle_pct = 85;
    bit hold_req    = 1'b0;
    int beats_sent  = 0;

    ascii_to_unsigned_parser #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_character(i_character),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_value    (o_value),
        .o_status   (o_status),
        .i_stall    (i_stall)
    );

    a2u_result_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_char   (i_character),
        .i_in_stall  (o_stall),
        .i_out_valid (o_valid),
        .i_out_value (o_value),
        .i_out_status(o_status),
        .i_out_stall (i_stall),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Output-side stall. A hold-off request freezes the receiver so the
    // parser's queue fills and it stalls input.
    initial begin : rx_stall_gen
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // One beat: random idle cycles first, then hold the character until taken.
    // Called at a rising edge; returns at the edge that took the beat.
    task automatic send_beat(input logic [7:0] ch);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= ch;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    // Digit character of value d (0..35); letters come in either case.
    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) begin
            return CHAR_ZERO + 8'(d);
        end
        return ($urandom_range(0, 1) ? CHAR_LC_A : CHAR_UC_A) + 8'(d - 10);
    endfunction

    // A character that breaks the string: either not alphanumeric at all
    // (any nonzero byte, high bit included) or a digit not below the base.
    function automatic logic [7:0] bad_char(input logic [5:0] base);
        logic [7:0] c;
        if ($urandom_range(0, 1)) begin
            return digit_char($urandom_range(int'(base), 35));
        end
        do begin
            c = 8'($urandom_range(1, 255));
        end while ((c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_LC_A && c <= CHAR_LC_Z)
                   || (c >= CHAR_UC_A && c <= CHAR_UC_Z));
        return c;
    endfunction

    task automatic send_random_string();
        int         kind;
        int         n_digits;
        int         bad_at;
        int         k;
        logic [5:0] base;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            // well-formed number with random prefix and content, sometimes broken
            case ($urandom_range(0, 3))
                0: begin
                    base = BASE_DEC;
                end
                1: begin
                    send_beat(CHAR_ZERO);
                    base = BASE_DEC;
                end
                2: begin
                    send_beat(CHAR_ZERO);
                    send_beat(CHAR_LC_X);
                    base = BASE_HEX;
                end
                default: begin
                    send_beat(CHAR_ZERO);
                    send_beat(CHAR_LC_O);
                    base = BASE_OCT;
                end
            endcase
            n_digits = $urandom_range(0, 14);   // long ones wrap the accumulator
            bad_at   = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n_digits) : -1;
            for (k = 0; k < n_digits; k++) begin
                if (k == bad_at) begin
                    send_beat(bad_char(base));
                end
                send_beat(digit_char($urandom_range(0, int'(base) - 1)));
            end
            if (bad_at == n_digits) begin
                send_beat(bad_char(base));
            end
        end else if (kind < 88) begin
            // leading zero then a capital X or O: a digit, never a prefix
            send_beat(CHAR_ZERO);
            send_beat($urandom_range(0, 1) ? "X" : "O");
            repeat ($urandom_range(0, 3)) send_beat(digit_char($urandom_range(0, 15)));
        end else begin
            // raw noise, possibly empty
            repeat ($urandom_range(0, 6)) send_beat(8'($urandom_range(1, 255)));
        end
        send_beat(CHAR_NUL);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_beat(s[k]);
        end
        send_beat(CHAR_NUL);
    endtask

    task automatic run_random(input int n_beats);
        int start;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            send_random_string();
        end
        i_valid <= 1'b0;
    endtask

    // Sender pause: let every predicted result come out before going on.
    task automatic drain_results();
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_character <= CHAR_NUL;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: empty string, lone prefixes, capital X / O
        // after a leading zero, hex letters in both cases, digit too big
        // for octal and decimal, a non-alphanumeric byte followed by a digit
        send_text("");
        send_text("0");
        send_text("0x");
        send_text("0o");
        send_text("0X");
        send_text("0O");
        send_text("0xfF");
        send_text("0o8");
        send_text("z");
        send_beat(8'hFF);
        send_beat("9");
        send_beat(CHAR_NUL);

        // sender idles lightly, receiver heavily
        run_random(BEATS_PER_PHASE);
        drain_results();

        // the other way round
        tx_idle_pct = 85;
        rx_idle_pct = 31;
        run_random(BEATS_PER_PHASE);
        drain_results();

        // full rate, opening with a long output hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        run_random(BEATS_PER_PHASE);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ascii_to_unsigned_parser] OK");
        end else begin
            $display("[ascii_to_unsigned_parser] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #4ms;
        $display("[ascii_to_unsigned_parser] ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/a2u_pkg.sv
design/a2u_front.sv
design/a2u_queue.sv
design/a2u_back.sv
design/ascii_to_unsigned_parser.sv
test/a2u_result_checker.sv
test/tb_top.sv
